/* hw/rtl/cpp_pkg.sv */
// Shared constants and types for the closest pair of points core.
`timescale 1ns / 1ps

package cpp_pkg;

    // Capacity of the point buffer and the widths that follow from it.
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Fixed field widths.
    localparam int COORD_W = 16;
    localparam int MAG_W   = 16;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int POINT_W = 2 * COORD_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic [POINT_W-1:0]        t_point;
    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic [CNT_W-1:0]          t_count;

endpackage

/* hw/rtl/cpp_if.sv */
// Valid/ready stream interfaces for points in and results out.
`timescale 1ns / 1ps

interface cpp_in_if;
    import cpp_pkg::*;

    logic   valid;
    logic   ready;
    t_coord x;
    t_coord y;
    logic   last;

    modport source (output valid, output x, output y, output last, input ready);
    modport sink   (input valid, input x, input y, input last, output ready);
endinterface

interface cpp_out_if;
    import cpp_pkg::*;

    logic   valid;
    logic   ready;
    t_dist  dist_sq;
    t_coord first_x;
    t_coord first_y;
    t_coord second_x;
    t_coord second_y;
    logic   found;
    logic   overflow;

    modport source (
        output valid, output dist_sq, output first_x, output first_y,
        output second_x, output second_y, output found, output overflow,
        input ready
    );
    modport sink (
        input valid, input dist_sq, input first_x, input first_y,
        input second_x, input second_y, input found, input overflow,
        output ready
    );
endinterface

/* hw/rtl/closest_pair_of_points_core.sv */
// Closest pair of points core: point buffer, pair sequencer and shared squarer.
`timescale 1ns / 1ps

//  Channel   Dir  Payload                                            Transfer
//  i_pt      in   x, y (signed 16), last                             valid & ready
//  o_res     out  dist_sq (33), first_x/y, second_x/y, found, overflow  valid & ready
//
//  Loading takes one point per cycle; i_pt.ready is high only while loading.
//  After the last point the search visits every pair of the n stored points
//  before the result is offered: each pair takes a buffer read, a difference
//  step, a squaring of x and then of y in the single 16x16 squarer and an
//  add-and-compare step, and each outer point adds a read and a latch of it.
//  The result is held on o_res until it is taken; the transfer clears the set.
//  Reset (synchronous, active low) empties the set; buffer contents are kept.

module closest_pair_of_points_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpp_in_if.sink       i_pt,
    cpp_out_if.source    o_res
);
    import cpp_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_LOAD  = 4'd0;  // taking points
    localparam logic [3:0] S_START = 4'd1;  // decide whether a search is needed
    localparam logic [3:0] S_ROW   = 4'd2;  // read the outer point
    localparam logic [3:0] S_ROWW  = 4'd3;  // latch the outer point
    localparam logic [3:0] S_RD    = 4'd4;  // read the inner point
    localparam logic [3:0] S_DIFF  = 4'd5;  // coordinate difference magnitudes
    localparam logic [3:0] S_SQX   = 4'd6;  // square the x difference
    localparam logic [3:0] S_SQY   = 4'd7;  // square the y difference
    localparam logic [3:0] S_CMP   = 4'd8;  // sum and compare with the best
    localparam logic [3:0] S_OUT   = 4'd9;  // result waiting for its transfer

    logic [3:0]         r_state;
    logic [3:0]         n_state;

    // Point buffer, written while loading and read one word per cycle.
    t_point             r_mem [MAX_POINTS];
    t_point             r_rd;
    t_addr              w_rd_addr;
    logic               w_in_xfer;
    logic               w_out_xfer;
    logic               w_has_room;

    t_count             r_count;
    logic               r_dropped;
    t_addr              r_i;
    t_addr              r_j;
    t_point             r_pi;

    logic [MAG_W-1:0]   r_dx;
    logic [MAG_W-1:0]   r_dy;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;

    logic               r_have;
    t_dist              r_best;
    t_point             r_best_a;
    t_point             r_best_b;

    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic [MAG_W-1:0]   w_mul_a;
    logic [SQ_W-1:0]    w_prod;
    t_dist              w_dist;
    logic               w_better;
    logic               w_last_j;
    logic               w_last_i;

    assign w_in_xfer  = i_pt.valid && i_pt.ready;
    assign w_out_xfer = o_res.valid && o_res.ready;
    assign w_has_room = r_count < CNT_W'(MAX_POINTS);

    // The outer point is read only in its own state; otherwise the inner index.
    assign w_rd_addr = (r_state == S_ROW) ? r_i : r_j;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_has_room) begin
            r_mem[r_count[ADDR_W-1:0]] <= {i_pt.x, i_pt.y};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Coordinate differences of the outer point and the freshly read point.
    // Each magnitude is at most 65535 and fits in 16 bits.
    assign w_dx = {r_pi[POINT_W-1], r_pi[POINT_W-1:COORD_W]}
                - {r_rd[POINT_W-1], r_rd[POINT_W-1:COORD_W]};
    assign w_dy = {r_pi[COORD_W-1], r_pi[COORD_W-1:0]}
                - {r_rd[COORD_W-1], r_rd[COORD_W-1:0]};

    // One squarer serves both axes on successive cycles.
    assign w_mul_a = (r_state == S_SQX) ? r_dx : r_dy;
    assign w_prod  = SQ_W'(w_mul_a) * SQ_W'(w_mul_a);

    assign w_dist   = DIST_W'(r_sqx) + DIST_W'(r_sqy);
    // Only a strictly smaller distance replaces the kept pair, so ties keep
    // the pair met first in load order.
    assign w_better = !r_have || (w_dist < r_best);
    assign w_last_j = {1'b0, r_j} == (r_count - CNT_W'(1));
    assign w_last_i = {1'b0, r_i} == (r_count - CNT_W'(2));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_xfer && i_pt.last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (r_count < CNT_W'(2)) ? S_OUT : S_ROW;
            end
            S_ROW:  n_state = S_ROWW;
            S_ROWW: n_state = S_RD;
            S_RD:   n_state = S_DIFF;
            S_DIFF: n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_CMP;
            S_CMP: begin
                if (!w_last_j) begin
                    n_state = S_RD;
                end else if (w_last_i) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_have    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                if (w_has_room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (r_state == S_START) begin
                r_have <= 1'b0;
            end else if (r_state == S_CMP) begin
                r_have <= 1'b1;
            end
            if (w_out_xfer) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_START: begin
                r_i      <= '0;
                r_best   <= '0;
                r_best_a <= '0;
                r_best_b <= '0;
            end
            S_ROWW: begin
                r_pi <= r_rd;
                r_j  <= r_i + ADDR_W'(1);
            end
            S_DIFF: begin
                r_dx <= w_dx[COORD_W] ? MAG_W'(-w_dx) : w_dx[MAG_W-1:0];
                r_dy <= w_dy[COORD_W] ? MAG_W'(-w_dy) : w_dy[MAG_W-1:0];
            end
            S_SQX: r_sqx <= w_prod;
            S_SQY: r_sqy <= w_prod;
            S_CMP: begin
                if (w_better) begin
                    r_best   <= w_dist;
                    r_best_a <= r_pi;
                    r_best_b <= r_rd;
                end
                if (!w_last_j) begin
                    r_j <= r_j + ADDR_W'(1);
                end else begin
                    r_i <= r_i + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    // r_rd still holds the inner point through S_CMP, since the read address
    // stays on r_j until the index moves.
    assign i_pt.ready      = (r_state == S_LOAD);
    assign o_res.valid     = (r_state == S_OUT);
    assign o_res.dist_sq   = r_best;
    assign o_res.first_x   = r_best_a[POINT_W-1:COORD_W];
    assign o_res.first_y   = r_best_a[COORD_W-1:0];
    assign o_res.second_x  = r_best_b[POINT_W-1:COORD_W];
    assign o_res.second_y  = r_best_b[COORD_W-1:0];
    assign o_res.found     = r_have;
    assign o_res.overflow  = r_dropped;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pt.ready && o_res.valid))
        else $error("input taken while a result is pending");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.found |-> o_res.dist_sq == '0)
        else $error("result without a pair carries a nonzero distance");

    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |=> r_count == '0 && !r_dropped && i_pt.ready)
        else $error("set not cleared after the result transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count past capacity");
`endif

endmodule
